@@ hw/rtl/ckhc_pkg.sv @@
// ----------------------------------------------------------------------------
// ckhc_pkg: shared types and constants of the canonical k-mer hash counter
// Holds the field widths, the hash seed, the sequencer states and the
// window-to-engine request struct.
// ----------------------------------------------------------------------------
`default_nettype none

package ckhc_pkg;

   localparam int KMER_W   = 62;
   localparam int KLEN_W   = 5;
   localparam int CHAR_W   = 8;
   localparam int SLOT_W   = 12;
   localparam int OCC_W    = 8;
   localparam int PROBE_W  = 12;

   localparam logic [63:0]       HASH_SEED  = 64'd5381;
   localparam logic [CHAR_W-1:0] CHAR_N     = 8'h4E;
   localparam logic [OCC_W-1:0]  OCC_MAX    = 8'hFF;
   localparam logic [PROBE_W-1:0] PROBE_MAX = 12'hFFF;
   localparam int                HASH_BYTES = 8;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_HASH,
      ST_CLEAR,
      ST_READ,
      ST_CHECK,
      ST_DONE
   } state_type;

   // counted k-mer handed from the window to the table engine
   typedef struct packed {
      logic              valid;
      logic [KMER_W-1:0] kmer;
   } kmer_req_type;

   // one DJB step: h*33 + byte
   function automatic logic [63:0] djb_step(input logic [63:0] h,
                                            input logic [7:0] b);
      djb_step = (h << 5) + h + {56'd0, b};
   endfunction

endpackage

`default_nettype wire

@@ hw/rtl/ckhc_ram.sv @@
// ----------------------------------------------------------------------------
// ckhc_ram: generic single-port-write, single-read synchronous RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ckhc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

@@ hw/rtl/ckhc_window.sv @@
// ----------------------------------------------------------------------------
// ckhc_window: rolling forward / reverse-complement windows
// Updates the windows on each base and emits the canonical k-mer once the
// window is full and the k-mer is nonzero.
// ----------------------------------------------------------------------------
`default_nettype none

module ckhc_window
   import ckhc_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              take,
   input  wire logic [CHAR_W-1:0] base_char,
   input  wire logic              record_start,
   input  wire logic [KLEN_W-1:0] kmer_length,
   output      kmer_req_type      kmer_req
);

   logic [KMER_W-1:0] fwd_ff, fwd_in, rev_ff, rev_in;
   logic [KLEN_W-1:0] fill_ff, fill_in;
   logic [KLEN_W-1:0] k_eff;
   logic [63:0]       kmask;
   logic [1:0]        code;
   logic [63:0]       rev_wide, ins;
   logic [KMER_W-1:0] canon;
   logic              clr;

   // window update
   always_comb begin
      clr      = record_start || (base_char == CHAR_N);
      k_eff    = (kmer_length == '0) ? KLEN_W'(1) : kmer_length;
      kmask    = (64'd1 << {k_eff, 1'b0}) - 64'd1;
      code     = base_char[2:1];
      ins      = {62'd0, code ^ 2'b10} << {(k_eff - KLEN_W'(1)), 1'b0};
      rev_wide = ({2'b00, rev_ff} >> 2) | ins;
      fwd_in   = fwd_ff;
      rev_in   = rev_ff;
      fill_in  = fill_ff;
      if (take) begin
         if (clr) begin
            fwd_in  = '0;
            rev_in  = '0;
            fill_in = '0;
         end else begin
            fwd_in  = KMER_W'((({2'b00, fwd_ff} << 2) | {62'd0, code}) & kmask);
            rev_in  = KMER_W'(rev_wide & kmask);
            fill_in = (fill_ff < k_eff) ? fill_ff + KLEN_W'(1) : k_eff;
         end
      end
      canon = (fwd_in > rev_in) ? rev_in : fwd_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_ff  <= '0;
         rev_ff  <= '0;
         fill_ff <= '0;
      end else begin
         fwd_ff  <= fwd_in;
         rev_ff  <= rev_in;
         fill_ff <= fill_in;
      end
   end

   // count request
   assign kmer_req.valid = take && !clr && (canon != '0) && (fill_in == k_eff);
   assign kmer_req.kmer  = canon;

endmodule

`default_nettype wire

@@ hw/rtl/ckhc_engine.sv @@
// ----------------------------------------------------------------------------
// ckhc_engine: hash and linear-probe sequencer over the key/count memories
// Hashes one byte per cycle, clears the memories after reset, then probes
// one slot at a time (read, then check) and writes back on a hit.
// ----------------------------------------------------------------------------
`default_nettype none

module ckhc_engine
   import ckhc_pkg::*;
#(
   parameter int TABLE_ENTRIES = 4096
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  kmer_req_type            kmer_req,
   output      logic               busy,
   output      logic               rsp_valid,
   output      logic [KMER_W-1:0]  rsp_kmer_value,
   output      logic [SLOT_W-1:0]  rsp_slot_index,
   output      logic [OCC_W-1:0]   rsp_occurrence,
   output      logic               rsp_new_entry,
   output      logic [PROBE_W-1:0] rsp_probe_count,
   output      logic               rsp_table_full
);

   localparam int AW = $clog2(TABLE_ENTRIES);
   localparam int CW = AW + 1;

   state_type state_ff, state_in;

   logic [KMER_W-1:0] kmer_ff, kmer_in;
   logic [63:0]       hash_ff, hash_in;
   logic [2:0]        byte_ff, byte_in;
   logic [AW-1:0]     slot_ff, slot_in, home_ff, home_in;
   logic              down_ff, down_in;
   logic [CW-1:0]     steps_ff, steps_in;
   logic [AW-1:0]     clr_ff, clr_in;

   logic              wr_en;
   logic [AW-1:0]     wr_addr, rd_addr;
   logic [KMER_W-1:0] key_wdata, key_rdata;
   logic [OCC_W-1:0]  occ_wdata, occ_rdata;
   logic [63:0]       kmer_shift;
   logic              hit, empty;

   ckhc_ram #(.WIDTH(KMER_W), .DEPTH(TABLE_ENTRIES)) u_key_ram (
      .clock, .wr_en, .wr_addr, .wr_data(key_wdata), .rd_addr, .rd_data(key_rdata)
   );
   ckhc_ram #(.WIDTH(OCC_W), .DEPTH(TABLE_ENTRIES)) u_occ_ram (
      .clock, .wr_en, .wr_addr, .wr_data(occ_wdata), .rd_addr, .rd_data(occ_rdata)
   );

   assign empty      = (key_rdata == '0);
   assign hit        = empty || (key_rdata == kmer_ff);
   assign kmer_shift = {2'b00, kmer_ff} >> {byte_ff, 3'b000};
   assign rd_addr    = slot_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: if (clr_ff == AW'(TABLE_ENTRIES - 1)) state_in = ST_IDLE;
         ST_IDLE:  if (kmer_req.valid) state_in = ST_HASH;
         ST_HASH:  if (byte_ff == 3'(HASH_BYTES - 1)) state_in = ST_READ;
         ST_READ:  state_in = ST_CHECK;
         ST_CHECK: begin
            if (hit || steps_ff == CW'(TABLE_ENTRIES - 1)) state_in = ST_DONE;
            else                                          state_in = ST_READ;
         end
         ST_DONE:  state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // datapath
   always_comb begin
      kmer_in  = kmer_ff;
      hash_in  = hash_ff;
      byte_in  = byte_ff;
      slot_in  = slot_ff;
      home_in  = home_ff;
      down_in  = down_ff;
      steps_in = steps_ff;
      clr_in   = clr_ff;
      case (state_ff)
         ST_CLEAR: clr_in = clr_ff + AW'(1);
         ST_IDLE: begin
            kmer_in  = kmer_req.kmer;
            hash_in  = HASH_SEED;
            byte_in  = '0;
            steps_in = '0;
         end
         ST_HASH: begin
            hash_in = djb_step(hash_ff, kmer_shift[7:0]);
            byte_in = byte_ff + 3'd1;
            if (byte_ff == 3'(HASH_BYTES - 1)) begin
               home_in = hash_in[AW-1:0];
               slot_in = hash_in[AW-1:0];
               down_in = hash_in[AW-1];
            end
         end
         ST_CHECK: begin
            if (!hit) begin
               steps_in = steps_ff + CW'(1);
               slot_in  = down_ff ? slot_ff - AW'(1) : slot_ff + AW'(1);
            end
         end
         default: ;
      endcase
   end

   // memory write: clearing sweep or update on a hit
   always_comb begin
      wr_en     = 1'b0;
      wr_addr   = slot_ff;
      key_wdata = kmer_ff;
      occ_wdata = (occ_rdata == OCC_MAX) ? OCC_MAX : occ_rdata + OCC_W'(1);
      case (state_ff)
         ST_CLEAR: begin
            wr_en     = 1'b1;
            wr_addr   = clr_ff;
            key_wdata = '0;
            occ_wdata = '0;
         end
         ST_CHECK: wr_en = hit;
         default: ;
      endcase
   end

   // result register
   always_ff @(posedge clock) begin
      if (state_ff == ST_CHECK) begin
         rsp_kmer_value <= kmer_ff;
         if (hit) begin
            rsp_slot_index  <= SLOT_W'(slot_ff);
            rsp_occurrence  <= occ_wdata;
            rsp_new_entry   <= empty;
            rsp_table_full  <= 1'b0;
            rsp_probe_count <= (CW > PROBE_W && steps_ff > CW'(PROBE_MAX)) ? PROBE_MAX
                               : PROBE_W'(steps_ff);
         end else begin
            rsp_slot_index  <= SLOT_W'(home_ff);
            rsp_occurrence  <= '0;
            rsp_new_entry   <= 1'b0;
            rsp_table_full  <= 1'b1;
            rsp_probe_count <= (CW > PROBE_W && TABLE_ENTRIES > 4095) ? PROBE_MAX
                               : PROBE_W'(TABLE_ENTRIES);
         end
      end
   end

   always_ff @(posedge clock) begin
      kmer_ff  <= kmer_in;
      hash_ff  <= hash_in;
      byte_ff  <= byte_in;
      slot_ff  <= slot_in;
      home_ff  <= home_in;
      down_ff  <= down_in;
      steps_ff <= steps_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
      end
   end

   // outputs
   always_comb begin
      busy      = (state_ff != ST_IDLE);
      rsp_valid = (state_ff == ST_DONE);
   end

endmodule

`default_nettype wire

@@ hw/rtl/canonical_kmer_hash_counter.sv @@
// ----------------------------------------------------------------------------
// canonical_kmer_hash_counter: canonical k-mer counter, open-addressing table
//
//   channel | ports                      | handshake
//   request | req_base_char, req_record_start | start & !busy
//   result  | rsp_* fields               | rsp_valid, one cycle, no stall
//   csr     | csr_data (kmer_length)     | csr_valid & csr_ready
//
// A request with no count leaves busy low. A counted k-mer passes through the
// hash states, a read and a check state per probed slot, and a result state,
// as set by the one-byte hash step and the read/check loop on the key memory.
// After reset the memories are swept with busy high.
// The result receiver cannot stall; each result shows for one cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module canonical_kmer_hash_counter
   import ckhc_pkg::*;
#(
   parameter int TABLE_ENTRIES = 4096
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output      logic               busy,
   input  wire logic [CHAR_W-1:0]  req_base_char,
   input  wire logic               req_record_start,
   input  wire logic               csr_valid,
   output      logic               csr_ready,
   input  wire logic [KLEN_W-1:0]  csr_data,
   output      logic               rsp_valid,
   output      logic [KMER_W-1:0]  rsp_kmer_value,
   output      logic [SLOT_W-1:0]  rsp_slot_index,
   output      logic [OCC_W-1:0]   rsp_occurrence,
   output      logic               rsp_new_entry,
   output      logic [PROBE_W-1:0] rsp_probe_count,
   output      logic               rsp_table_full
);

   logic [KLEN_W-1:0] klen_ff;
   kmer_req_type      kmer_req;
   logic              take;

   assign csr_ready = 1'b1;
   assign take      = start && !busy;

   // configuration register
   always_ff @(posedge clock) begin
      if (reset)                klen_ff <= KLEN_W'(30);
      else if (csr_valid)       klen_ff <= csr_data;
   end

   ckhc_window u_window (
      .clock, .reset, .take,
      .base_char(req_base_char), .record_start(req_record_start),
      .kmer_length(klen_ff), .kmer_req
   );

   ckhc_engine #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_engine (
      .clock, .reset, .kmer_req, .busy,
      .rsp_valid, .rsp_kmer_value, .rsp_slot_index, .rsp_occurrence,
      .rsp_new_entry, .rsp_probe_count, .rsp_table_full
   );

   // a full table never reports a new entry
   a_full_not_new: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_table_full |-> !rsp_new_entry && rsp_occurrence == '0)
      else $error("table full with an update");
   // a result is never a zero k-mer
   a_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_kmer_value != '0)
      else $error("zero k-mer counted");
   // results are single-cycle pulses
   a_pulse: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result longer than one cycle");

endmodule

`default_nettype wire
